@@ src/trce_pkg.sv @@
// shared types, constants and opcode codes for the toy register cpu execute block
package trce_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned NUM_REGS    = 7;
    localparam int unsigned OPC_W       = 5;
    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned STK_CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned IN_TUSER_W  = 8;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [REG_IDX_W-1:0] EXT_REG_IDX = 3'd7;
    localparam logic [DATA_W-1:0]    PC_STEP     = 16'd4;

    typedef enum logic [OPC_W-1:0] {
        OP_NOOP       = 5'd0,
        OP_MOVE       = 5'd1,
        OP_IMMEDIATE  = 5'd2,
        OP_RESET      = 5'd3,
        OP_PUSH       = 5'd4,
        OP_POP        = 5'd5,
        OP_ADD        = 5'd6,
        OP_SUB        = 5'd7,
        OP_AND        = 5'd8,
        OP_OR         = 5'd9,
        OP_NAND       = 5'd10,
        OP_NOR        = 5'd11,
        OP_XOR        = 5'd12,
        OP_XNOR       = 5'd13,
        OP_NOT        = 5'd14,
        OP_GREATER    = 5'd15,
        OP_EQUAL      = 5'd16,
        OP_NOT_EQUAL  = 5'd17,
        OP_LESS       = 5'd18,
        OP_ADDI       = 5'd19,
        OP_SUBI       = 5'd20,
        OP_GREATERI   = 5'd21,
        OP_EQUALI     = 5'd22,
        OP_NOT_EQUALI = 5'd23,
        OP_LESSI      = 5'd24,
        OP_JUMPI      = 5'd25,
        OP_DBG        = 5'd26,
        OP_EXIT       = 5'd27
    } t_opcode;

    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_ALU,
        CLS_PUSH,
        CLS_POP,
        CLS_BRANCH,
        CLS_JUMP,
        CLS_EXIT
    } t_cls;

    typedef enum logic [3:0] {
        ALU_PASS,
        ALU_ZERO,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NAND,
        ALU_NOR,
        ALU_XOR,
        ALU_XNOR,
        ALU_NOT
    } t_alu;

    typedef enum logic [1:0] {
        CMP_GT,
        CMP_EQ,
        CMP_NE,
        CMP_LT
    } t_cmp;

    // decoded instruction handed from the front to the back
    typedef struct packed {
        t_cls                 cls;
        t_alu                 alu;
        t_cmp                 cmp;
        logic                 a_imm;
        logic                 b_imm;
        logic [REG_IDX_W-1:0] idx_a;
        logic [REG_IDX_W-1:0] idx_b;
        logic [REG_IDX_W-1:0] dest;
        logic [DATA_W-1:0]    imm_a;
        logic [DATA_W-1:0]    imm_b;
        logic [DATA_W-1:0]    target;
        logic [DATA_W-1:0]    ext;
    } t_uop;

    typedef struct packed {
        logic                 stack_fault;
        logic                 halted;
        logic                 branch_taken;
        logic [DATA_W-1:0]    write_value;
        logic [REG_IDX_W-1:0] write_index;
        logic                 reg_write;
        logic [DATA_W-1:0]    next_pc;
    } t_result;

endpackage

@@ src/trce_front.sv @@
// front end: takes instruction transfers and decodes them into micro-ops
module trce_front
    import trce_pkg::*;
(
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // operand_a, operand_b, operand_c, ext_input
    input  logic [IN_TUSER_W-1:0] s_axis_tuser,  // opcode, zero fill
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output t_uop                  o_push_uop
);

    logic [OPC_W-1:0]  opcode;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] opnd_c;
    logic [DATA_W-1:0] ext_in;

    assign opcode = s_axis_tuser[OPC_W-1:0];
    assign opnd_a = s_axis_tdata[15:0];
    assign opnd_b = s_axis_tdata[31:16];
    assign opnd_c = s_axis_tdata[47:32];
    assign ext_in = s_axis_tdata[63:48];

    assign s_axis_tready = i_push_ready;
    assign o_push_valid  = s_axis_tvalid;

    always_comb begin
        o_push_uop        = '0;
        o_push_uop.cls    = CLS_NOP;
        o_push_uop.alu    = ALU_PASS;
        o_push_uop.cmp    = CMP_EQ;
        o_push_uop.idx_a  = opnd_a[REG_IDX_W-1:0];
        o_push_uop.idx_b  = opnd_b[REG_IDX_W-1:0];
        o_push_uop.dest   = opnd_c[REG_IDX_W-1:0];
        o_push_uop.imm_a  = opnd_a;
        o_push_uop.imm_b  = opnd_b;
        o_push_uop.target = opnd_c;
        o_push_uop.ext    = ext_in;
        case (opcode)
            OP_MOVE: begin
                o_push_uop.cls = CLS_ALU;
            end
            OP_IMMEDIATE: begin
                o_push_uop.cls   = CLS_ALU;
                o_push_uop.a_imm = 1'b1;
            end
            OP_RESET: begin
                o_push_uop.cls  = CLS_ALU;
                o_push_uop.alu  = ALU_ZERO;
                o_push_uop.dest = opnd_a[REG_IDX_W-1:0];
            end
            OP_PUSH:  o_push_uop.cls = CLS_PUSH;
            OP_POP:   o_push_uop.cls = CLS_POP;
            OP_ADD: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_ADD;
            end
            OP_SUB: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_SUB;
            end
            OP_AND: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_AND;
            end
            OP_OR: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_OR;
            end
            OP_NAND: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_NAND;
            end
            OP_NOR: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_NOR;
            end
            OP_XOR: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_XOR;
            end
            OP_XNOR: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_XNOR;
            end
            OP_NOT: begin
                o_push_uop.cls = CLS_ALU;
                o_push_uop.alu = ALU_NOT;
            end
            OP_GREATER: begin
                o_push_uop.cls = CLS_BRANCH;
                o_push_uop.cmp = CMP_GT;
            end
            OP_EQUAL: begin
                o_push_uop.cls = CLS_BRANCH;
                o_push_uop.cmp = CMP_EQ;
            end
            OP_NOT_EQUAL: begin
                o_push_uop.cls = CLS_BRANCH;
                o_push_uop.cmp = CMP_NE;
            end
            OP_LESS: begin
                o_push_uop.cls = CLS_BRANCH;
                o_push_uop.cmp = CMP_LT;
            end
            OP_ADDI: begin
                o_push_uop.cls   = CLS_ALU;
                o_push_uop.alu   = ALU_ADD;
                o_push_uop.b_imm = 1'b1;
            end
            OP_SUBI: begin
                o_push_uop.cls   = CLS_ALU;
                o_push_uop.alu   = ALU_SUB;
                o_push_uop.b_imm = 1'b1;
            end
            OP_GREATERI: begin
                o_push_uop.cls   = CLS_BRANCH;
                o_push_uop.cmp   = CMP_GT;
                o_push_uop.b_imm = 1'b1;
            end
            OP_EQUALI: begin
                o_push_uop.cls   = CLS_BRANCH;
                o_push_uop.cmp   = CMP_EQ;
                o_push_uop.b_imm = 1'b1;
            end
            OP_NOT_EQUALI: begin
                o_push_uop.cls   = CLS_BRANCH;
                o_push_uop.cmp   = CMP_NE;
                o_push_uop.b_imm = 1'b1;
            end
            OP_LESSI: begin
                o_push_uop.cls   = CLS_BRANCH;
                o_push_uop.cmp   = CMP_LT;
                o_push_uop.b_imm = 1'b1;
            end
            OP_JUMPI: begin
                // target is operand_c times four, wrapped to 16 bits
                o_push_uop.cls    = CLS_JUMP;
                o_push_uop.target = {opnd_c[DATA_W-3:0], 2'b00};
            end
            OP_EXIT:  o_push_uop.cls = CLS_EXIT;
            default:  o_push_uop.cls = CLS_NOP;
        endcase
    end

endmodule

@@ src/trce_queue.sv @@
// short fifo of decoded micro-ops between front and back
module trce_queue
    import trce_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_uop i_push_uop,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_uop o_pop_uop
);

    t_uop               r_mem [QUEUE_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != Q_CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_uop    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_uop;
        end
    end

endmodule

@@ src/trce_back.sv @@
// back end: register read stage, execute stage with state, output register
module trce_back
    import trce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_uop_valid,
    output logic    o_uop_ready,
    input  t_uop    i_uop,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_result o_res
);

    // architectural state
    logic [DATA_W-1:0]    r_regs  [NUM_REGS];
    logic [DATA_W-1:0]    r_stack [STACK_DEPTH];
    logic [DATA_W-1:0]    r_pc;
    logic [STK_CNT_W-1:0] r_cnt;
    logic                 r_halt;

    // read stage
    logic                 r_rd_valid;
    t_cls                 r_rd_cls;
    t_alu                 r_rd_alu;
    t_cmp                 r_rd_cmp;
    logic [REG_IDX_W-1:0] r_rd_dest;
    logic [DATA_W-1:0]    r_rd_target;
    logic [DATA_W-1:0]    r_rd_opa;
    logic [DATA_W-1:0]    r_rd_opb;

    // output register
    logic                 r_out_valid;
    t_result              r_out;

    logic                 out_ready;
    logic                 ex_fire;
    logic                 rd_load;
    logic [DATA_W-1:0]    rd_opa;
    logic [DATA_W-1:0]    rd_opb;

    logic [DATA_W-1:0]    pc_seq;
    logic [DATA_W-1:0]    alu_val;
    logic                 cmp_hit;
    logic [STK_CNT_W-1:0] cnt_m1;
    logic [STK_CNT_W-1:0] n_cnt;
    logic                 push_en;
    logic                 wr_req;
    logic                 wr_en;
    logic [DATA_W-1:0]    wr_val;
    logic                 taken;
    logic                 fault;
    logic                 halt_set;
    logic [DATA_W-1:0]    n_pc;
    t_result              n_out;

    assign out_ready   = !r_out_valid || i_res_ready;
    assign ex_fire     = r_rd_valid && out_ready;
    assign rd_load     = !r_rd_valid || ex_fire;
    assign o_uop_ready = rd_load;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // register read with bypass from the instruction finishing this cycle
    function automatic logic [DATA_W-1:0] read_reg(
        input logic [REG_IDX_W-1:0] idx,
        input logic [DATA_W-1:0]    ext,
        input logic                 fwd_en,
        input logic [REG_IDX_W-1:0] fwd_idx,
        input logic [DATA_W-1:0]    fwd_val,
        input logic [DATA_W-1:0]    reg_val
    );
        logic [DATA_W-1:0] val;
        if (idx == EXT_REG_IDX) begin
            val = ext;
        end else if (fwd_en && (fwd_idx == idx)) begin
            val = fwd_val;
        end else begin
            val = reg_val;
        end
        return val;
    endfunction

    always_comb begin
        rd_opa = i_uop.imm_a;
        rd_opb = i_uop.imm_b;
        if (!i_uop.a_imm) begin
            rd_opa = read_reg(i_uop.idx_a, i_uop.ext, ex_fire && wr_en, r_rd_dest, wr_val,
                              (i_uop.idx_a == EXT_REG_IDX) ? '0 : r_regs[i_uop.idx_a]);
        end
        if (!i_uop.b_imm) begin
            rd_opb = read_reg(i_uop.idx_b, i_uop.ext, ex_fire && wr_en, r_rd_dest, wr_val,
                              (i_uop.idx_b == EXT_REG_IDX) ? '0 : r_regs[i_uop.idx_b]);
        end
    end

    // execute
    always_comb begin
        case (r_rd_alu)
            ALU_PASS: alu_val = r_rd_opa;
            ALU_ZERO: alu_val = '0;
            ALU_ADD:  alu_val = r_rd_opa + r_rd_opb;
            ALU_SUB:  alu_val = r_rd_opa - r_rd_opb;
            ALU_AND:  alu_val = r_rd_opa & r_rd_opb;
            ALU_OR:   alu_val = r_rd_opa | r_rd_opb;
            ALU_NAND: alu_val = ~(r_rd_opa & r_rd_opb);
            ALU_NOR:  alu_val = ~(r_rd_opa | r_rd_opb);
            ALU_XOR:  alu_val = r_rd_opa ^ r_rd_opb;
            ALU_XNOR: alu_val = ~(r_rd_opa ^ r_rd_opb);
            ALU_NOT:  alu_val = ~r_rd_opa;
            default:  alu_val = '0;
        endcase
        case (r_rd_cmp)
            CMP_GT:  cmp_hit = (r_rd_opa > r_rd_opb);
            CMP_EQ:  cmp_hit = (r_rd_opa == r_rd_opb);
            CMP_NE:  cmp_hit = (r_rd_opa != r_rd_opb);
            CMP_LT:  cmp_hit = (r_rd_opa < r_rd_opb);
            default: cmp_hit = 1'b0;
        endcase
    end

    assign pc_seq = r_pc + PC_STEP;
    assign cnt_m1 = r_cnt - STK_CNT_W'(1);

    always_comb begin
        wr_req   = 1'b0;
        wr_val   = '0;
        taken    = 1'b0;
        fault    = 1'b0;
        halt_set = 1'b0;
        push_en  = 1'b0;
        n_cnt    = r_cnt;
        case (r_rd_cls)
            CLS_ALU: begin
                wr_req = 1'b1;
                wr_val = alu_val;
            end
            CLS_PUSH: begin
                if (r_cnt < STK_CNT_W'(STACK_DEPTH)) begin
                    push_en = 1'b1;
                    n_cnt   = r_cnt + STK_CNT_W'(1);
                end else begin
                    fault = 1'b1;
                end
            end
            CLS_POP: begin
                // underflow writes zero
                wr_req = 1'b1;
                if (r_cnt != '0) begin
                    wr_val = r_stack[cnt_m1[STK_AW-1:0]];
                    n_cnt  = cnt_m1;
                end else begin
                    fault = 1'b1;
                end
            end
            CLS_BRANCH: taken = cmp_hit;
            CLS_JUMP:   taken = 1'b1;
            CLS_EXIT:   halt_set = 1'b1;
            default: ;
        endcase
        n_pc = taken ? r_rd_target : pc_seq;
        // once halted, items leave the state alone
        if (r_halt) begin
            wr_req  = 1'b0;
            wr_val  = '0;
            taken   = 1'b0;
            fault   = 1'b0;
            push_en = 1'b0;
            n_cnt   = r_cnt;
            n_pc    = r_pc;
        end
        wr_en = wr_req && (r_rd_dest != EXT_REG_IDX);

        n_out.next_pc      = n_pc;
        n_out.reg_write    = wr_en;
        n_out.write_index  = wr_en ? r_rd_dest : '0;
        n_out.write_value  = wr_en ? wr_val : '0;
        n_out.branch_taken = taken;
        n_out.halted       = r_halt || halt_set;
        n_out.stack_fault  = fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
            r_pc        <= '0;
            r_cnt       <= '0;
            r_halt      <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_load) begin
                r_rd_valid <= i_uop_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_rd_valid;
            end
            if (ex_fire) begin
                r_pc   <= n_pc;
                r_cnt  <= n_cnt;
                r_halt <= r_halt || halt_set;
                if (wr_en) begin
                    r_regs[r_rd_dest] <= wr_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_load && i_uop_valid) begin
            r_rd_cls    <= i_uop.cls;
            r_rd_alu    <= i_uop.alu;
            r_rd_cmp    <= i_uop.cmp;
            r_rd_dest   <= i_uop.dest;
            r_rd_target <= i_uop.target;
            r_rd_opa    <= rd_opa;
            r_rd_opb    <= rd_opb;
        end
        if (ex_fire) begin
            r_out <= n_out;
        end
        if (ex_fire && push_en) begin
            r_stack[r_cnt[STK_AW-1:0]] <= r_rd_opa;
        end
    end

endmodule

@@ src/toy_register_cpu_execute_top.sv @@
// top level of the toy register cpu execute block: front, micro-op queue, back
// path: a transfer enters the queue, then the register read stage, then the output register
// throughput: one instruction per cycle when not stalled; the execute stage holds all state
// reset: synchronous active-low i_rst_n clears registers, pc, stack count, halt flag,
//   the queue and all valid bits; stack contents are not cleared
module toy_register_cpu_execute_top
    import trce_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // operand_a, operand_b, operand_c, ext_input
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // opcode, zero fill
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // next_pc, reg_write, write_index, write_value, branch_taken, halted,
    // stack_fault, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // front to queue
    logic    fe_valid;
    logic    fe_ready;
    t_uop    fe_uop;

    // queue to back
    logic    q_valid;
    logic    q_ready;
    t_uop    q_uop;

    t_result be_res;

    // decode runs in the same cycle as the input transfer
    trce_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (fe_valid),
        .i_push_ready  (fe_ready),
        .o_push_uop    (fe_uop)
    );

    // two-entry decoupling queue, lets the front keep taking transfers
    // while the back waits on the output side
    trce_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_ready (fe_ready),
        .i_push_uop   (fe_uop),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_uop    (q_uop)
    );

    // register read, execute and result register; the read stage bypasses
    // the write of the instruction retiring in the same cycle
    trce_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (q_valid),
        .o_uop_ready (q_ready),
        .i_uop       (q_uop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (be_res)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {1'b0,
                           be_res.stack_fault,
                           be_res.halted,
                           be_res.branch_taken,
                           be_res.write_value,
                           be_res.write_index,
                           be_res.reg_write,
                           be_res.next_pc};

endmodule

@@ src/trce_check.sv @@
// port-level checker for the toy register cpu execute block, with its bind
module trce_check
    import trce_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a halted result carries no write, branch or fault
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[37] |->
            !m_axis_tdata[16] && !m_axis_tdata[36] && !m_axis_tdata[38])
        else $error("halted result has side effects");

    // no write reports zero index and value; a write never targets the input port
    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[16] ? (m_axis_tdata[19:17] != EXT_REG_IDX)
                              : (m_axis_tdata[35:17] == '0)))
        else $error("write fields inconsistent");

endmodule

bind toy_register_cpu_execute_top trce_check u_trce_check (.*);
